@@ src/wcel_pkg.sv @@
`default_nettype none
package wcel_pkg;
    localparam int MAX_CLASSES_DEF = 64;
    localparam int PPB_LOG2_DEF = 20;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int NUM_CLASSES_W = 7;
    localparam int IGN_CNT_W = 2;
    localparam int LABEL_W = 8;
    localparam int PROB_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int LOSS_W = 24;
    localparam int NLN_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_B = 2'd3;
    localparam logic [15:0] WEIGHT_ONE = 16'd256;
    localparam logic FUNC_WEIGHT = 1'b0;

    typedef struct packed {
        logic        start;
        logic [15:0] p;
    } t_log_req;
endpackage
`default_nettype wire

@@ src/wcel_ram.sv @@
`default_nettype none
module wcel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ src/wcel_neglog.sv @@
`default_nettype none
// -ln(p) Q.16 by iterative squaring, one square per cycle
module wcel_neglog (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wcel_pkg::t_log_req i_req,
    output logic                  o_done,
    output logic [wcel_pkg::NLN_W-1:0] o_nln
);
    import wcel_pkg::*;
    logic [16:0] r_x;
    logic [19:0] r_frac;
    logic [4:0]  r_e;
    logic [4:0]  r_cnt;
    logic        r_busy, r_mul;
    logic [55:0] r_prod;
    logic [33:0] sq;
    logic [16:0] xs;
    logic [3:0]  msb;
    logic [15:0] pc;
    logic [24:0] l;

    always_comb begin
        pc = (i_req.p == '0) ? 16'd1 : i_req.p;
        msb = '0;
        for (int k = 0; k < 16; k++) if (pc[k]) msb = 4'(k);
        sq = r_x * r_x;
        xs = 17'(sq >> 15);
        l = {5'(5'd16 - r_e), 20'd0} - {5'd0, r_frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_e <= {1'b0, msb};
                r_x <= 17'({1'b0, pc} << (4'd15 - msb));
                r_frac <= '0;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_frac <= {r_frac[18:0], xs[16]};
                r_x <= xs[16] ? (xs >> 1) : xs;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd19) begin
                    r_busy <= 1'b0;
                    r_mul <= 1'b1;
                end
            end else if (r_mul) begin
                r_mul <= 1'b0;
                o_done <= 1'b1;
            end
        end
        if (r_mul) r_prod <= l * LN2_Q32 + (56'd1 << 35);
    end
    assign o_nln = NLN_W'(r_prod[55:36]);

`ifndef SYNTHESIS
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(r_busy && r_mul))
        else $error("log unit busy and multiplying");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> $past(r_mul))
        else $error("done without multiply");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> r_cnt < 5'd20)
        else $error("count overrun");
`endif
endmodule
`default_nettype wire

@@ src/wcel_divider.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module wcel_divider #(
    parameter int NW = 48,
    parameter int DW = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   sh;
    always_comb sh = {r_rem[DW-1:0], r_q[NW-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_cnt <= '0;
            end else if (r_busy) begin
                if (sh >= {1'b0, r_den}) begin
                    r_rem <= sh - {1'b0, r_den};
                    r_q <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= sh;
                    r_q <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule
`default_nettype wire

@@ src/weighted_cross_entropy_loss.sv @@
`default_nettype none
// Weight writes and class elements that end no pixel are accepted back to back.
// A scored pixel end holds ready low through table read, 20 squarings, scale
// multiply, weight multiply and accumulate; a skipped or out-of-range pixel only for the read.
// A batch end adds a bit-serial divide; an empty batch skips the divide.
// A finished result is held in the output register while input continues.
// Synchronous active-low reset; weight table resets to 1.0 by valid bits.
module weighted_cross_entropy_loss #(
    parameter int MAX_CLASSES = wcel_pkg::MAX_CLASSES_DEF,
    parameter int PIXELS_PER_BATCH_LOG2 = wcel_pkg::PPB_LOG2_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // class_index[5:0], class_weight[21:6], prob[37:22], label[45:38], pad
    input  wire logic [47:0] s_axis_tdata,
    // func[0], last_in_batch[1]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // loss[23:0]
    output logic [23:0]      m_axis_tdata,
    // label_error[0], empty_res[1]
    output logic [1:0]       m_axis_tuser
);
    import wcel_pkg::*;

    localparam int LSW = 28 + PIXELS_PER_BATCH_LOG2;
    localparam int WSW = 20 + PIXELS_PER_BATCH_LOG2;
    localparam int LAW = (LSW > 40 ? LSW : 40) + 1;
    localparam int AW = $clog2(MAX_CLASSES);
    localparam int CCW = $clog2(MAX_CLASSES + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_RD = 6'b000010, S_LOG = 6'b000100,
        S_ACC = 6'b001000, S_DIV = 6'b010000, S_OUT = 6'b100000
    } t_state;
    t_state r_state;

    logic [6:0] r_nc;
    logic [1:0] r_ic;
    logic [7:0] r_ia, r_ib;
    logic [MAX_CLASSES-1:0] r_wval;
    logic [LSW-1:0] r_lsum;
    logic [WSW-1:0] r_wsum;
    logic [CCW-1:0] r_cc;
    logic [15:0] r_pp, r_pfin;
    logic [7:0] r_lab;
    logic r_err, r_batch, r_vld;
    logic [15:0] r_w;
    logic [39:0] r_wl;
    logic [23:0] r_loss;
    logic r_empty, r_oerr;

    logic func, lbatch, acc;
    logic [5:0] cidx;
    logic [15:0] cw, prob;
    logic [7:0] lab;
    logic [15:0] p_now, rdata;
    logic [7:0] nc8;
    logic ign, oor;
    logic log_done, div_done;
    logic [NLN_W-1:0] nln;
    logic [LSW-1:0] quo;
    t_log_req lreq;

    assign cidx = s_axis_tdata[5:0];
    assign cw = s_axis_tdata[21:6];
    assign prob = s_axis_tdata[37:22];
    assign lab = s_axis_tdata[45:38];
    assign func = s_axis_tuser[0];
    assign lbatch = s_axis_tuser[1];
    assign o_cfg_ready = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && !r_batch;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign p_now = (32'(lab) == 32'(r_cc)) ? prob : r_pp;
    assign nc8 = (r_nc > 7'(MAX_CLASSES > 127 ? 127 : MAX_CLASSES) && MAX_CLASSES < 128)
                 ? 8'(MAX_CLASSES) : {1'b0, r_nc};
    assign ign = (r_ic != 2'd0 && r_lab == r_ia) || (r_ic[1] && r_lab == r_ib);
    assign oor = {1'b0, r_lab} >= {1'b0, nc8};
    assign lreq.start = (r_state == S_RD) && !ign && !oor;
    assign lreq.p = r_pfin;

    wcel_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_wtab (
        .i_clk(i_clk), .i_we(acc && func == FUNC_WEIGHT && 32'(cidx) < MAX_CLASSES),
        .i_waddr(AW'(cidx)), .i_wdata(cw), .i_raddr(AW'(lab)), .o_rdata(rdata));

    wcel_neglog u_log (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(lreq),
        .o_done(log_done), .o_nln(nln));

    wcel_divider #(.NW(LSW), .DW(WSW)) u_div (.i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == S_IDLE && r_batch && !r_vld && r_wsum != '0),
        .i_num(r_lsum), .i_den(r_wsum), .o_done(div_done), .o_quo(quo));

    logic [LAW-1:0] lsum_add;
    logic [WSW:0] wsum_add;
    assign lsum_add = LAW'(r_lsum) + LAW'(r_wl);
    assign wsum_add = {1'b0, r_wsum} + (WSW+1)'(r_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nc <= 7'd64; r_ic <= '0; r_ia <= 8'hFF; r_ib <= 8'hFF;
            r_wval <= '0; r_lsum <= '0; r_wsum <= '0; r_cc <= '0; r_pp <= '0;
            r_err <= 1'b0; r_batch <= 1'b0; r_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NUM_CLASSES: r_nc <= i_cfg_data[6:0];
                    CFG_IGNORE_COUNT: r_ic <= i_cfg_data[1:0] == 2'd3 ? 2'd2 : i_cfg_data[1:0];
                    CFG_IGNORE_A: r_ia <= i_cfg_data;
                    CFG_IGNORE_B: r_ib <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (r_batch && !r_vld) begin
                        if (r_wsum == '0) begin
                            r_loss <= '0; r_empty <= 1'b1; r_oerr <= r_err;
                            r_state <= S_OUT;
                        end else r_state <= S_DIV;
                    end else if (acc) begin
                        if (func == FUNC_WEIGHT) begin
                            if (32'(cidx) < MAX_CLASSES) r_wval[AW'(cidx)] <= 1'b1;
                        end else if (s_axis_tlast || lbatch) begin
                            r_lab <= lab; r_pfin <= p_now; r_batch <= lbatch;
                            r_cc <= '0; r_pp <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_pp <= p_now;
                            if (r_cc < CCW'(MAX_CLASSES)) r_cc <= r_cc + 1'b1;
                        end
                    end
                end
                S_RD: begin
                    r_w <= r_wval[AW'(r_lab)] ? rdata : WEIGHT_ONE;
                    if (ign) r_state <= S_IDLE;
                    else if (oor) begin r_err <= 1'b1; r_state <= S_IDLE; end
                    else r_state <= S_LOG;
                end
                S_LOG: if (log_done) begin
                    r_wl <= r_w * nln;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_lsum <= (lsum_add[LAW-1:LSW] != '0) ? '1 : lsum_add[LSW-1:0];
                    r_wsum <= wsum_add[WSW] ? '1 : wsum_add[WSW-1:0];
                    r_state <= S_IDLE;
                end
                S_DIV: if (div_done) begin
                    r_loss <= (quo > LSW'(24'hFFFFFF)) ? 24'hFFFFFF : quo[23:0];
                    r_empty <= 1'b0; r_oerr <= r_err;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_vld <= 1'b1; r_batch <= 1'b0;
                    r_lsum <= '0; r_wsum <= '0; r_err <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata = r_loss;
    assign m_axis_tuser = {r_empty, r_oerr};

`ifndef SYNTHESIS
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tdata == '0)
        else $error("empty result with loss");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_vld) else $error("result lost");
`endif
endmodule
`default_nettype wire
